@@ src/cles_pkg.sv @@
// ---------------------------------------------------------------------------
// cles_pkg: shared definitions for the character LCD expander sequencer
// Opcodes, LCD command bytes, delays, queue entry layout and init tables.
// ---------------------------------------------------------------------------
`default_nettype none

package cles_pkg;

    // Display geometry.
    localparam int COLUMNS = 16;
    localparam int ROWS    = 2;
    localparam logic [7:0] COLUMNS_B = 8'(COLUMNS);
    localparam logic [2:0] ROWS_B    = 3'(ROWS);

    // Command queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request opcodes.
    localparam logic [2:0] OP_CHAR    = 3'd0;
    localparam logic [2:0] OP_COMMAND = 3'd1;
    localparam logic [2:0] OP_CURSOR  = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_HOME    = 3'd4;
    localparam logic [2:0] OP_LIGHT   = 3'd5;
    localparam logic [2:0] OP_INIT    = 3'd6;

    // LCD command bytes and character codes.
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] CMD_DISPLAY  = 8'h0C;
    localparam logic [7:0] CMD_FUNCTION = 8'h28;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] ROW1_OFFSET  = 8'h40;
    localparam logic [7:0] NIB_WAKE     = 8'h30;
    localparam logic [7:0] NIB_FOUR_BIT = 8'h20;
    localparam logic [7:0] HIGH_NIBBLE  = 8'hF0;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // Delays in microseconds.
    localparam logic [15:0] DELAY_NONE       = 16'd0;
    localparam logic [15:0] DELAY_STROBE     = 16'd1;
    localparam logic [15:0] DELAY_SETTLE     = 16'd50;
    localparam logic [15:0] DELAY_CLEAR      = 16'd2050;
    localparam logic [15:0] DELAY_WAKE_FIRST = 16'd5050;
    localparam logic [15:0] DELAY_WAKE       = 16'd200;
    localparam logic [15:0] DELAY_POWER_UP   = 16'd50000;

    // Nibble sequencing.
    localparam int NIB_W = 4;
    localparam logic [NIB_W-1:0] INIT_LAST_NIB = 4'd11;
    localparam logic [NIB_W-1:0] BYTE_LAST_NIB = 4'd1;

    localparam logic [1:0] PH_DATA    = 2'd0;
    localparam logic [1:0] PH_STROBE  = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_LIGHT = 2'd1,
        KIND_INIT  = 2'd2
    } kind_t;

    // One classified request waiting for the back part.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;      // LCD byte for KIND_BYTE
        logic       rs_on;      // OR in the register select pattern
        logic       long_tail;  // clear or home: long final wait
        logic       light_on;   // backlight state for this request
    } entry_t;

    typedef struct packed {
        logic [7:0] rs;
        logic [7:0] en;
        logic [7:0] bl;
    } masks_t;

    function automatic logic [7:0] hi_nib(input logic [7:0] v);
        hi_nib = v & HIGH_NIBBLE;
    endfunction

    function automatic logic [7:0] lo_nib(input logic [7:0] v);
        lo_nib = {v[3:0], 4'h0};
    endfunction

    // Nibbles of the power-up sequence, in the upper four bits.
    function automatic logic [7:0] init_nibble(input logic [NIB_W-1:0] idx);
        unique case (idx)
            4'd0, 4'd1, 4'd2: init_nibble = NIB_WAKE;
            4'd3:  init_nibble = NIB_FOUR_BIT;
            4'd4:  init_nibble = hi_nib(CMD_FUNCTION);
            4'd5:  init_nibble = lo_nib(CMD_FUNCTION);
            4'd6:  init_nibble = hi_nib(CMD_DISPLAY);
            4'd7:  init_nibble = lo_nib(CMD_DISPLAY);
            4'd8:  init_nibble = hi_nib(CMD_ENTRY);
            4'd9:  init_nibble = lo_nib(CMD_ENTRY);
            4'd10: init_nibble = hi_nib(CMD_CLEAR);
            4'd11: init_nibble = lo_nib(CMD_CLEAR);
            default: init_nibble = 8'h00;
        endcase
    endfunction

    // Wait after the enable-low write of each power-up nibble.
    function automatic logic [15:0] init_delay(input logic [NIB_W-1:0] idx);
        unique case (idx)
            4'd0:             init_delay = DELAY_WAKE_FIRST;
            4'd1, 4'd2, 4'd3: init_delay = DELAY_WAKE;
            4'd11:            init_delay = DELAY_CLEAR;
            default:          init_delay = DELAY_SETTLE;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ src/cles_if.sv @@
// ---------------------------------------------------------------------------
// cles_if: request and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ---------------------------------------------------------------------------
`default_nettype none

interface cles_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic [4:0] cursor_column;
    logic [1:0] cursor_row;
    logic       backlight_request;

    modport source (output valid, opcode, data_byte, cursor_column, cursor_row,
                    backlight_request, input ready);
    modport sink   (input valid, opcode, data_byte, cursor_column, cursor_row,
                    backlight_request, output ready);
endinterface

interface cles_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  expander_byte;
    logic        bus_write;
    logic [15:0] delay_after_us;
    logic        last_of_run;

    modport source (output valid, expander_byte, bus_write, delay_after_us,
                    last_of_run, input ready);
    modport sink   (input valid, expander_byte, bus_write, delay_after_us,
                    last_of_run, output ready);
endinterface

`default_nettype wire

@@ src/char_lcd_expander_sequencer_unit.sv @@
// ---------------------------------------------------------------------------
// char_lcd_expander_sequencer_unit: character LCD sequencer, expander side
// Turns LCD requests into timed port expander writes for a 4-bit display.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Beat carries
//  -------   ---------  ------------------------------------------------------
//  req       in         opcode, data_byte, cursor_column, cursor_row,
//                       backlight_request
//  rsp       out        expander_byte, bus_write, delay_after_us, last_of_run
//  cfg_*     in         register index and data, written when cfg_write is high
//
//  A request is classified in the cycle it is accepted and enters a two-entry
//  queue; the back part emits one result beat per cycle from the queue head
//  unless rsp stalls. A character or command is sent as its high and low nibble,
//  backlight as a single beat and init as a power-up wait followed by its
//  nibbles. Dropped requests produce no beats. rsp is stalled independently
//  through its output register; req is stalled only when the queue is full.
//  Reset is asynchronous and active low; it restores the default masks and turns the backlight state on.
// ---------------------------------------------------------------------------
`default_nettype none

module char_lcd_expander_sequencer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    cles_req_if.sink        req,
    cles_rsp_if.source      rsp
);

    // Configuration register indexes.
    localparam logic [1:0] CFG_RS_MASK = 2'd0;
    localparam logic [1:0] CFG_EN_MASK = 2'd1;
    localparam logic [1:0] CFG_BL_MASK = 2'd2;

    cles_pkg::masks_t masks_reg;
    cles_pkg::entry_t push_entry;
    cles_pkg::entry_t head;
    logic             push;
    logic             q_full;
    logic             pop;
    logic             head_valid;

    // The user must write the masks only while the block is idle, so the back
    // part can read them directly; the block does not enforce this. A write to the unused index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masks_reg.rs <= 8'h01;
            masks_reg.en <= 8'h04;
            masks_reg.bl <= 8'h08;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RS_MASK: masks_reg.rs <= cfg_data;
                CFG_EN_MASK: masks_reg.en <= cfg_data;
                CFG_BL_MASK: masks_reg.bl <= cfg_data;
                default:     masks_reg    <= masks_reg;
            endcase
        end
    end

    // Front part: classifies each request and tracks the backlight state,
    // so every queued entry carries the backlight bit it must be sent with.
    cles_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_full (q_full),
        .push   (push),
        .entry  (push_entry)
    );

    cles_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back part: expands the head entry into nibble writes with delays; a backlight entry becomes a single write.
    cles_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .masks      (masks_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

@@ src/cles_front.sv @@
// ---------------------------------------------------------------------------
// cles_front: request classifier
// Turns each request beat into a queue entry and keeps the backlight state.
// ---------------------------------------------------------------------------
`default_nettype none

module cles_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    cles_req_if.sink             req,
    input  wire logic            q_full,
    output logic                 push,
    output cles_pkg::entry_t     entry
);

    logic       light_reg;
    logic       light_next;
    logic       accept;
    logic       produce;
    logic       newline;
    logic [4:0] cur_col;
    logic [1:0] cur_row;
    logic       cursor_ok;
    logic [7:0] row_off;
    logic [7:0] cursor_cmd;

    assign req.ready = !q_full;
    assign accept    = req.valid && req.ready;
    assign push      = accept && produce;

    assign light_next = (req.opcode == cles_pkg::OP_LIGHT) ? req.backlight_request
                                                           : light_reg;

    // A newline is a cursor move to the start of the second row.
    assign newline = (req.data_byte == cles_pkg::CHAR_NEWLINE);
    assign cur_col = (req.opcode == cles_pkg::OP_CHAR) ? 5'd0 : req.cursor_column;
    assign cur_row = (req.opcode == cles_pkg::OP_CHAR) ? 2'd1 : req.cursor_row;

    assign cursor_ok = (8'(cur_col) < cles_pkg::COLUMNS_B)
                    && ({1'b0, cur_row} < cles_pkg::ROWS_B);

    always_comb
    begin
        row_off = 8'h00;
        if (cur_row[0])
        begin
            row_off = cles_pkg::ROW1_OFFSET;
        end
        if (cur_row[1])
        begin
            row_off = row_off + cles_pkg::COLUMNS_B;
        end
    end

    assign cursor_cmd = cles_pkg::CMD_SET_ADDR | (8'(cur_col) + row_off);

    always_comb
    begin
        entry.kind      = cles_pkg::KIND_BYTE;
        entry.value     = req.data_byte;
        entry.rs_on     = 1'b0;
        entry.long_tail = 1'b0;
        entry.light_on  = light_next;
        produce         = 1'b1;
        unique case (req.opcode)
            cles_pkg::OP_CHAR:
            begin
                if (newline)
                begin
                    entry.value = cursor_cmd;
                    produce     = cursor_ok;
                end
                else
                begin
                    entry.rs_on = 1'b1;
                end
            end
            cles_pkg::OP_COMMAND:
            begin
                entry.value = req.data_byte;
            end
            cles_pkg::OP_CURSOR:
            begin
                entry.value = cursor_cmd;
                produce     = cursor_ok;
            end
            cles_pkg::OP_CLEAR:
            begin
                entry.value     = cles_pkg::CMD_CLEAR;
                entry.long_tail = 1'b1;
            end
            cles_pkg::OP_HOME:
            begin
                entry.value     = cles_pkg::CMD_HOME;
                entry.long_tail = 1'b1;
            end
            cles_pkg::OP_LIGHT:
            begin
                entry.kind = cles_pkg::KIND_LIGHT;
            end
            cles_pkg::OP_INIT:
            begin
                entry.kind = cles_pkg::KIND_INIT;
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg <= 1'b1;
        end
        else if (accept)
        begin
            light_reg <= light_next;
        end
    end

endmodule

`default_nettype wire

@@ src/cles_queue.sv @@
// ---------------------------------------------------------------------------
// cles_queue: command queue
// Short FIFO of classified requests between the front and the back part.
// ---------------------------------------------------------------------------
`default_nettype none

module cles_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire cles_pkg::entry_t push_entry,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output cles_pkg::entry_t      head
);

    cles_pkg::entry_t              slots [cles_pkg::QUEUE_DEPTH];
    logic [cles_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [cles_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [cles_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [cles_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [cles_pkg::QCNT_W-1:0]   count_reg;
    logic [cles_pkg::QCNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    localparam logic [cles_pkg::QPTR_W-1:0] LAST_SLOT =
        cles_pkg::QPTR_W'(cles_pkg::QUEUE_DEPTH - 1);
    localparam logic [cles_pkg::QCNT_W-1:0] FULL_COUNT =
        cles_pkg::QCNT_W'(cles_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == FULL_COUNT);
    assign head_valid = (count_reg != '0);
    assign head       = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ src/cles_back.sv @@
// ---------------------------------------------------------------------------
// cles_back: expander write sequencer
// Walks the queue head through its nibbles and writes one result per cycle unless rsp stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module cles_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cles_pkg::masks_t masks,
    input  wire logic             head_valid,
    input  wire cles_pkg::entry_t head,
    output logic                  pop,
    cles_rsp_if.source            rsp
);

    logic [cles_pkg::NIB_W-1:0] nib_reg;
    logic [cles_pkg::NIB_W-1:0] nib_next;
    logic [1:0]                 phase_reg;
    logic [1:0]                 phase_next;
    logic                       waited_reg;
    logic                       waited_next;
    logic                       out_valid_reg;
    logic [7:0]                 out_byte_reg;
    logic                       out_write_reg;
    logic [15:0]                out_delay_reg;
    logic                       out_last_reg;

    logic                       out_free;
    logic                       advance;
    logic [7:0]                 bl_bits;
    logic [7:0]                 nib_val;
    logic [15:0]                tail_delay;
    logic [cles_pkg::NIB_W-1:0] last_nib;
    logic [7:0]                 beat_byte;
    logic                       beat_write;
    logic [15:0]                beat_delay;
    logic                       beat_last;
    logic                       beat_is_wait;

    assign out_free = !out_valid_reg || rsp.ready;
    assign advance  = head_valid && out_free;
    assign pop      = advance && beat_last;
    assign bl_bits  = head.light_on ? masks.bl : 8'h00;

    always_comb
    begin
        if (head.kind == cles_pkg::KIND_INIT)
        begin
            nib_val    = cles_pkg::init_nibble(nib_reg);
            tail_delay = cles_pkg::init_delay(nib_reg);
            last_nib   = cles_pkg::INIT_LAST_NIB;
        end
        else
        begin
            nib_val    = (nib_reg == '0) ? cles_pkg::hi_nib(head.value)
                                         : cles_pkg::lo_nib(head.value);
            nib_val    = nib_val | (head.rs_on ? masks.rs : 8'h00);
            tail_delay = (nib_reg == cles_pkg::BYTE_LAST_NIB && head.long_tail)
                       ? cles_pkg::DELAY_CLEAR : cles_pkg::DELAY_SETTLE;
            last_nib   = cles_pkg::BYTE_LAST_NIB;
        end
    end

    // Power-up starts with a pure wait before its first nibble.
    assign beat_is_wait = (head.kind == cles_pkg::KIND_INIT) && !waited_reg;

    always_comb
    begin
        beat_byte  = 8'h00;
        beat_write = 1'b1;
        beat_delay = cles_pkg::DELAY_NONE;
        beat_last  = 1'b0;
        if (head.kind == cles_pkg::KIND_LIGHT)
        begin
            beat_byte = bl_bits;
            beat_last = 1'b1;
        end
        else if (beat_is_wait)
        begin
            beat_write = 1'b0;
            beat_delay = cles_pkg::DELAY_POWER_UP;
        end
        else
        begin
            unique case (phase_reg)
                cles_pkg::PH_DATA:
                begin
                    beat_byte = nib_val | bl_bits;
                end
                cles_pkg::PH_STROBE:
                begin
                    beat_byte  = nib_val | masks.en | bl_bits;
                    beat_delay = cles_pkg::DELAY_STROBE;
                end
                default:
                begin
                    beat_byte  = (nib_val & ~masks.en) | bl_bits;
                    beat_delay = tail_delay;
                    beat_last  = (nib_reg == last_nib);
                end
            endcase
        end
    end

    always_comb
    begin
        nib_next    = nib_reg;
        phase_next  = phase_reg;
        waited_next = waited_reg;
        if (advance)
        begin
            if (beat_last)
            begin
                nib_next    = '0;
                phase_next  = cles_pkg::PH_DATA;
                waited_next = 1'b0;
            end
            else if (beat_is_wait)
            begin
                waited_next = 1'b1;
            end
            else if (phase_reg == cles_pkg::PH_RELEASE)
            begin
                phase_next = cles_pkg::PH_DATA;
                nib_next   = nib_reg + 1'b1;
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nib_reg       <= '0;
            phase_reg     <= cles_pkg::PH_DATA;
            waited_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nib_reg    <= nib_next;
            phase_reg  <= phase_next;
            waited_reg <= waited_next;
            if (out_free)
            begin
                out_valid_reg <= head_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg  <= beat_byte;
            out_write_reg <= beat_write;
            out_delay_reg <= beat_delay;
            out_last_reg  <= beat_last;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.expander_byte  = out_byte_reg;
    assign rsp.bus_write      = out_write_reg;
    assign rsp.delay_after_us = out_delay_reg;
    assign rsp.last_of_run    = out_last_reg;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ---------------------------------------------------------------------------
// tb: self-checking bench for char_lcd_expander_sequencer_unit
// Drives LCD requests through the req channel, predicts every expander write
// they cause and compares the rsp beats against that prediction, under
// random idling on both channels and several register settings.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    import cles_pkg::*;

    // The spare opcode has no package name; the block must drop it.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // Cycles to let pass after the last expected beat before touching the
    // registers; an init is the longest run and the queue holds two entries.
    localparam int SETTLE_CYCLES   = 80;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 52;
    localparam int IDLE_PERCENT    = 12;

    typedef enum logic [1:0] {
        REG_RS    = 2'd0,
        REG_EN    = 2'd1,
        REG_BL    = 2'd2,
        REG_SPARE = 2'd3
    } reg_index_t;

    // How a stimulus row is checked: against the predictor, as a request
    // that must produce no beat, or as a single beat typed into the table.
    typedef enum logic [1:0] {
        ROW_PREDICT = 2'd0,
        ROW_SILENT  = 2'd1,
        ROW_SINGLE  = 2'd2
    } row_check_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic [4:0] col;
        logic [1:0] row;
        logic       light;
        row_check_t check;
        logic [7:0] typed_byte;
    } stim_row_t;

    // One expander write as it should appear on rsp.
    typedef struct packed {
        logic [7:0]  xbyte;
        logic        wr;
        logic [15:0] delay_us;
        logic        last;
    } lcd_write_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    cles_req_if req_ch ();
    cles_rsp_if rsp_ch ();

    char_lcd_expander_sequencer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Predictor state, mirroring the block's registers and backlight bit.
    logic [7:0] rs_mask  = 8'h01;
    logic [7:0] en_mask  = 8'h04;
    logic [7:0] bl_mask  = 8'h08;
    logic       light_on = 1'b1;

    lcd_write_t  lcd_writes_due [$];   // expected beats, oldest first
    lcd_write_t  request_writes [$];   // beats of the request being expanded
    stim_row_t   directed_rows  [$];
    int unsigned failures = 0;
    bit          steady   = 1'b0;      // suppresses idling on both channels

    // -----------------------------------------------------------------------
    // Clock and run limit.
    // -----------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The slowest correct run is roughly 300 requests of at most 37 beats,
    // stretched by receiver stalls, plus the settle pauses. This limit is
    // about twenty times that.
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Predictor. The tasks build the beats of one request in request_writes.
    // -----------------------------------------------------------------------
    task automatic emit(input logic [7:0] b, input logic wr, input logic [15:0] d);
        lcd_write_t w;
        w.xbyte    = b;
        w.wr       = wr;
        w.delay_us = d;
        w.last     = 1'b0;
        request_writes.push_back(w);
    endtask

    // A nibble is a data write, an enable strobe and a release that keeps
    // everything but the enable bits.
    task automatic emit_nibble(input logic [7:0] n);
        logic [7:0] lit;
        lit = light_on ? bl_mask : 8'h00;
        emit(n | lit, 1'b1, DELAY_NONE);
        emit(n | en_mask | lit, 1'b1, DELAY_STROBE);
        emit((n & ~en_mask) | lit, 1'b1, DELAY_SETTLE);
    endtask

    task automatic emit_lcd_byte(input logic [7:0] v, input logic [7:0] rs);
        emit_nibble((v & HIGH_NIBBLE) | rs);
        emit_nibble({v[3:0], 4'h0} | rs);
    endtask

    task automatic lengthen_last(input logic [15:0] extra);
        lcd_write_t w;
        w = request_writes.pop_back();
        w.delay_us = w.delay_us + extra;
        request_writes.push_back(w);
    endtask

    // Positions off the display produce nothing at all.
    task automatic emit_cursor(input logic [4:0] col, input logic [1:0] row);
        logic [7:0] off;
        if (row < ROWS && col < COLUMNS)
        begin
            off = row[0] ? ROW1_OFFSET : 8'h00;
            if (row[1])
                off = off + COLUMNS_B;
            emit_lcd_byte(CMD_SET_ADDR | ({3'b000, col} + off), 8'h00);
        end
    endtask

    task automatic expand_request(input stim_row_t r);
        lcd_write_t w;
        request_writes.delete();
        case (r.op)
            OP_CHAR:
                if (r.data == CHAR_NEWLINE)
                    emit_cursor(5'd0, 2'd1);
                else
                    emit_lcd_byte(r.data, rs_mask);
            OP_COMMAND:
                emit_lcd_byte(r.data, 8'h00);
            OP_CURSOR:
                emit_cursor(r.col, r.row);
            OP_CLEAR:
            begin
                emit_lcd_byte(CMD_CLEAR, 8'h00);
                lengthen_last(DELAY_CLEAR - DELAY_SETTLE);
            end
            OP_HOME:
            begin
                emit_lcd_byte(CMD_HOME, 8'h00);
                lengthen_last(DELAY_CLEAR - DELAY_SETTLE);
            end
            OP_LIGHT:
            begin
                light_on = r.light;
                emit(light_on ? bl_mask : 8'h00, 1'b1, DELAY_NONE);
            end
            OP_INIT:
            begin
                // Power-up wait, three wake nibbles, the switch to four bits,
                // then function set, display on, entry mode and a clear.
                emit(8'h00, 1'b0, DELAY_POWER_UP);
                emit_nibble(NIB_WAKE);
                lengthen_last(DELAY_WAKE_FIRST - DELAY_SETTLE);
                emit_nibble(NIB_WAKE);
                lengthen_last(DELAY_WAKE - DELAY_SETTLE);
                emit_nibble(NIB_WAKE);
                lengthen_last(DELAY_WAKE - DELAY_SETTLE);
                emit_nibble(NIB_FOUR_BIT);
                lengthen_last(DELAY_WAKE - DELAY_SETTLE);
                emit_lcd_byte(CMD_FUNCTION, 8'h00);
                emit_lcd_byte(CMD_DISPLAY, 8'h00);
                emit_lcd_byte(CMD_ENTRY, 8'h00);
                emit_lcd_byte(CMD_CLEAR, 8'h00);
                lengthen_last(DELAY_CLEAR - DELAY_SETTLE);
            end
            default:
            begin
            end
        endcase
        if (request_writes.size() > 0)
        begin
            w = request_writes.pop_back();
            w.last = 1'b1;
            request_writes.push_back(w);
        end
    endtask

    // -----------------------------------------------------------------------
    // Request side. Called at a falling edge; returns at a falling edge once
    // the beat has been taken. The expected beats are queued at the rising
    // edge that accepts the request, so they are always in place before the
    // first result can appear.
    // -----------------------------------------------------------------------
    task automatic offer_request(input stim_row_t r, output int unsigned produced);
        lcd_write_t w;
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid             <= 1'b1;
        req_ch.opcode            <= r.op;
        req_ch.data_byte         <= r.data;
        req_ch.cursor_column     <= r.col;
        req_ch.cursor_row        <= r.row;
        req_ch.backlight_request <= r.light;
        do
            @(posedge clk);
        while (!req_ch.ready);

        // The predictor runs on every row so the backlight bit stays in step,
        // even where the table supplies the expectation itself.
        expand_request(r);
        case (r.check)
            ROW_PREDICT:
                foreach (request_writes[i])
                    lcd_writes_due.push_back(request_writes[i]);
            ROW_SINGLE:
            begin
                w.xbyte    = r.typed_byte;
                w.wr       = 1'b1;
                w.delay_us = DELAY_NONE;
                w.last     = 1'b1;
                lcd_writes_due.push_back(w);
            end
            default:
            begin
            end
        endcase
        produced = request_writes.size();
        @(negedge clk);
    endtask

    task automatic add_row(input logic [2:0] op, input logic [7:0] data,
                           input logic [4:0] col, input logic [1:0] row,
                           input logic light, input row_check_t check,
                           input logic [7:0] typed_byte);
        stim_row_t r;
        r.op         = op;
        r.data       = data;
        r.col        = col;
        r.row        = row;
        r.light      = light;
        r.check      = check;
        r.typed_byte = typed_byte;
        directed_rows.push_back(r);
    endtask

    // Random requests are mostly characters and commands, with cursor moves
    // that usually land on the display, and a sprinkling of the rest. The
    // unused fields always carry random values so every input bit toggles.
    task automatic pick_request(output stim_row_t r);
        int unsigned roll;
        roll         = $urandom_range(0, 99);
        r.data       = 8'($urandom_range(0, 255));
        r.col        = 5'($urandom_range(0, 31));
        r.row        = 2'($urandom_range(0, 3));
        r.light      = 1'($urandom_range(0, 1));
        r.check      = ROW_PREDICT;
        r.typed_byte = 8'h00;
        if (roll < 40)
        begin
            r.op = OP_CHAR;
            if ($urandom_range(0, 9) == 0)
                r.data = CHAR_NEWLINE;
        end
        else if (roll < 52)
            r.op = OP_COMMAND;
        else if (roll < 67)
        begin
            r.op = OP_CURSOR;
            if ($urandom_range(0, 4) != 0)
            begin
                r.col = 5'($urandom_range(0, COLUMNS - 1));
                r.row = 2'($urandom_range(0, ROWS - 1));
            end
        end
        else if (roll < 71)
            r.op = OP_CLEAR;
        else if (roll < 75)
            r.op = OP_HOME;
        else if (roll < 85)
            r.op = OP_LIGHT;
        else if (roll < 89)
            r.op = OP_INIT;
        else if (roll < 93)
            r.op = OP_UNUSED;
        else
            r.op = 3'($urandom_range(0, 7));
    endtask

    // -----------------------------------------------------------------------
    // Register writes go out on consecutive cycles with the write enable held
    // high, and are mirrored into the predictor once all have been issued. Only
    // called while the block is idle.
    // -----------------------------------------------------------------------
    task automatic load_masks(input logic [7:0] rs, input logic [7:0] en,
                              input logic [7:0] bl, input bit poke_spare);
        cfg_write <= 1'b1;
        cfg_index <= REG_RS;
        cfg_data  <= rs;
        @(negedge clk);
        cfg_index <= REG_EN;
        cfg_data  <= en;
        @(negedge clk);
        cfg_index <= REG_BL;
        cfg_data  <= bl;
        @(negedge clk);
        if (poke_spare)
        begin
            // The spare index holds no register; the write must change nothing.
            cfg_index <= REG_SPARE;
            cfg_data  <= 8'($urandom_range(0, 255));
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        rs_mask = rs;
        en_mask = en;
        bl_mask = bl;
    endtask

    // Wait for every expected beat, then let the block settle. Dropped
    // requests leave nothing to wait on, so the pause covers them.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (lcd_writes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Result side: ready idles at random except in the steady stretch, and
    // each accepted beat is compared with the oldest expectation.
    // -----------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    task automatic compare_write();
        lcd_write_t w;
        if (lcd_writes_due.size() == 0)
        begin
            $error("unexpected beat: expander_byte 0x%02h", rsp_ch.expander_byte);
            failures++;
        end
        else
        begin
            w = lcd_writes_due.pop_front();
            if (rsp_ch.expander_byte !== w.xbyte)
            begin
                $error("expander_byte: expected 0x%02h, actual 0x%02h",
                       w.xbyte, rsp_ch.expander_byte);
                failures++;
            end
            if (rsp_ch.bus_write !== w.wr)
            begin
                $error("bus_write: expected %0d, actual %0d", w.wr, rsp_ch.bus_write);
                failures++;
            end
            if (rsp_ch.delay_after_us !== w.delay_us)
            begin
                $error("delay_after_us: expected %0d, actual %0d",
                       w.delay_us, rsp_ch.delay_after_us);
                failures++;
            end
            if (rsp_ch.last_of_run !== w.last)
            begin
                $error("last_of_run: expected %0d, actual %0d",
                       w.last, rsp_ch.last_of_run);
                failures++;
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                compare_write();
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus.
    // -----------------------------------------------------------------------
    initial
    begin
        stim_row_t   r;
        int unsigned produced;
        int unsigned counted;

        rst_n                    = 1'b0;
        cfg_write                = 1'b0;
        cfg_index                = REG_RS;
        cfg_data                 = 8'h00;
        req_ch.valid             = 1'b0;
        req_ch.opcode            = OP_CHAR;
        req_ch.data_byte         = 8'h00;
        req_ch.cursor_column     = 5'd0;
        req_ch.cursor_row        = 2'd0;
        req_ch.backlight_request = 1'b0;

        // Directed table, run with the reset masks. Typed rows are the
        // backlight beats, whose byte is just the mask or zero, and the
        // requests that must produce nothing: cursors off the display and
        // the unused opcode.
        add_row(OP_LIGHT,   8'h00,        5'd0,  2'd0, 1'b1, ROW_SINGLE,  8'h08);
        add_row(OP_CHAR,    8'h00,        5'd0,  2'd0, 1'b0, ROW_PREDICT, 8'h00);
        add_row(OP_CHAR,    8'hFF,        5'd31, 2'd3, 1'b1, ROW_PREDICT, 8'h00);
        add_row(OP_CHAR,    CHAR_NEWLINE, 5'd7,  2'd2, 1'b0, ROW_PREDICT, 8'h00);
        add_row(OP_COMMAND, 8'h00,        5'd0,  2'd0, 1'b0, ROW_PREDICT, 8'h00);
        add_row(OP_COMMAND, 8'hFF,        5'd31, 2'd3, 1'b1, ROW_PREDICT, 8'h00);
        add_row(OP_CURSOR,  8'h00,        5'd0,  2'd0, 1'b0, ROW_PREDICT, 8'h00);
        add_row(OP_CURSOR,  8'hFF,        5'd15, 2'd1, 1'b1, ROW_PREDICT, 8'h00);
        add_row(OP_CURSOR,  8'h00,        5'd16, 2'd0, 1'b0, ROW_SILENT,  8'h00);
        add_row(OP_CURSOR,  8'h00,        5'd0,  2'd2, 1'b0, ROW_SILENT,  8'h00);
        add_row(OP_CURSOR,  8'hFF,        5'd31, 2'd3, 1'b1, ROW_SILENT,  8'h00);
        add_row(OP_CLEAR,   8'h00,        5'd0,  2'd0, 1'b0, ROW_PREDICT, 8'h00);
        add_row(OP_HOME,    8'hFF,        5'd31, 2'd3, 1'b1, ROW_PREDICT, 8'h00);
        add_row(OP_LIGHT,   8'hFF,        5'd31, 2'd3, 1'b0, ROW_SINGLE,  8'h00);
        add_row(OP_CHAR,    8'h5A,        5'd0,  2'd0, 1'b0, ROW_PREDICT, 8'h00);
        add_row(OP_INIT,    8'h00,        5'd0,  2'd0, 1'b0, ROW_PREDICT, 8'h00);
        add_row(OP_LIGHT,   8'h00,        5'd0,  2'd0, 1'b1, ROW_SINGLE,  8'h08);
        add_row(OP_UNUSED,  8'h00,        5'd0,  2'd0, 1'b0, ROW_SILENT,  8'h00);
        add_row(OP_UNUSED,  8'hFF,        5'd31, 2'd3, 1'b1, ROW_SILENT,  8'h00);
        add_row(OP_INIT,    8'hFF,        5'd31, 2'd3, 1'b1, ROW_PREDICT, 8'h00);
        add_row(OP_CHAR,    8'h7E,        5'd5,  2'd1, 1'b1, ROW_PREDICT, 8'h00);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            offer_request(directed_rows[i], produced);

        // Random phases, each under its own register setting: all ones, all
        // zeros, two random settings and the reset values again. The third
        // phase runs with no idling on either channel.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0: load_masks(8'hFF, 8'hFF, 8'hFF, 1'b0);
                1: load_masks(8'h00, 8'h00, 8'h00, 1'b0);
                2: load_masks(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 1'b0);
                3: load_masks(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 1'b1);
                default: load_masks(8'h01, 8'h04, 8'h08, 1'b0);
            endcase
            steady  = (phase == 2);
            counted = 0;
            // Dropped requests do not count toward the phase's share.
            while (counted < ITEMS_PER_PHASE)
            begin
                pick_request(r);
                offer_request(r, produced);
                if (produced > 0)
                    counted++;
            end
        end
        steady = 1'b0;
        drain();

        if (failures == 0 && lcd_writes_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
